[design/blk58_pkg.sv]
// Shared constants, types and helper functions for the block base58 encoder.
// Used by blk58_ctrl, blk58_dpath and block_base58_encoder; no dependencies.
package blk58_pkg;

    // Bytes per block, digits per full block, and the widths that follow
    localparam int BLOCK_BYTES = 8;
    localparam int MAX_DIGITS  = 11;
    localparam int CHUNK_BITS  = 16;
    localparam int CHUNKS      = 64 / CHUNK_BITS;

    // Reciprocal of 58 for a 22-bit dividend: q = (x * RECIP_58) >> RECIP_SHIFT
    localparam int          RECIP_SHIFT = 27;
    localparam logic [21:0] RECIP_58    = 22'd2314099;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;     // input item taken this cycle
        logic       step;       // run one 16-bit long-division step
        logic       digit_wr;   // store the remainder as a finished digit
        logic [3:0] digit_idx;  // digit slot, least significant first
        logic [3:0] rd_idx;     // digit slot shown on the output
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic       flush;      // the byte on the input closes a block
        logic [3:0] len;        // characters in the block being converted
    } t_status;

    // Characters produced for a block of n bytes
    function automatic logic [3:0] run_length(input logic [3:0] n);
        logic [3:0] len;
        len = 4'd0;
        case (n)
            4'd1:    len = 4'd2;
            4'd2:    len = 4'd3;
            4'd3:    len = 4'd5;
            4'd4:    len = 4'd6;
            4'd5:    len = 4'd7;
            4'd6:    len = 4'd9;
            4'd7:    len = 4'd10;
            4'd8:    len = 4'd11;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // Base58 digit to ASCII, skipping 0, O, I and l
    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] dd;
        logic [6:0] c;
        dd = {1'b0, d};
        if (d <= 6'd8) begin
            c = dd + 7'd49;
        end else if (d <= 6'd16) begin
            c = dd + 7'd56;
        end else if (d <= 6'd21) begin
            c = dd + 7'd57;
        end else if (d <= 6'd32) begin
            c = dd + 7'd58;
        end else if (d <= 6'd43) begin
            c = dd + 7'd64;
        end else begin
            c = dd + 7'd65;
        end
        return c;
    endfunction

endpackage

[design/blk58_ctrl.sv]
// Controller for the block base58 encoder: byte intake, conversion sequencing
// and character output. Depends on blk58_pkg for the command and status types.
module blk58_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  blk58_pkg::t_status i_status,
    output blk58_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SEND
    } t_state;

    t_state     r_state;
    logic       r_s_ready;
    logic       r_m_valid;
    logic [1:0] r_chunk;
    logic [3:0] r_digit;
    logic [3:0] r_rd;
    logic       w_accept;
    logic       w_last_chunk;

    assign w_accept     = i_s_tvalid & r_s_ready;
    assign w_last_chunk = (r_chunk == 2'(blk58_pkg::CHUNKS - 1));

    // Drive datapath commands
    always_comb begin
        o_cmd.accept    = w_accept;
        o_cmd.step      = (r_state == S_CONV);
        o_cmd.digit_wr  = (r_state == S_CONV) & w_last_chunk;
        o_cmd.digit_idx = r_digit;
        o_cmd.rd_idx    = r_rd;
    end

    assign o_s_tready = r_s_ready;
    assign o_m_tvalid = r_m_valid;

    // Sequence: take bytes, divide the block digit by digit, send characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s_ready <= 1'b1;
            r_m_valid <= 1'b0;
            r_chunk   <= 2'd0;
            r_digit   <= 4'd0;
            r_rd      <= 4'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_status.flush) begin
                        r_state   <= S_CONV;
                        r_s_ready <= 1'b0;
                        r_chunk   <= 2'd0;
                        r_digit   <= 4'd0;
                    end
                end
                S_CONV: begin
                    r_chunk <= r_chunk + 2'd1;
                    if (w_last_chunk) begin
                        r_digit <= r_digit + 4'd1;
                        if (r_digit == i_status.len - 4'd1) begin
                            r_state   <= S_SEND;
                            r_m_valid <= 1'b1;
                            r_rd      <= r_digit;
                        end
                    end
                end
                S_SEND: begin
                    if (i_m_tready) begin
                        if (r_rd == 4'd0) begin
                            r_state   <= S_IDLE;
                            r_m_valid <= 1'b0;
                            r_s_ready <= 1'b1;
                        end else begin
                            r_rd <= r_rd - 4'd1;
                        end
                    end
                end
                default: begin
                    r_state   <= S_IDLE;
                    r_s_ready <= 1'b1;
                    r_m_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

[design/blk58_dpath.sv]
// Datapath for the block base58 encoder: byte accumulator, 16-bit-per-step
// division by 58 and digit store. Depends on blk58_pkg.
module blk58_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  blk58_pkg::t_cmd    i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic               i_final_byte,
    output blk58_pkg::t_status o_status,
    output logic [6:0]         o_char_code,
    output logic               o_block_end,
    output logic               o_message_end
);

    logic [63:0] r_acc;
    logic [2:0]  r_count;
    logic [63:0] r_work;
    logic [5:0]  r_rem;
    logic [3:0]  r_len;
    logic        r_last;
    logic [5:0]  r_digits [blk58_pkg::MAX_DIGITS];

    logic [63:0] n_acc;
    logic        w_flush;
    logic [21:0] w_x;
    logic [43:0] w_prod;
    logic [15:0] w_q;
    logic [5:0]  w_q58_lo;
    logic [5:0]  n_rem;

    // Gather the next byte, big-endian
    assign n_acc   = {r_acc[55:0], i_data_byte};
    assign w_flush = i_final_byte | (r_count == 3'(blk58_pkg::BLOCK_BYTES - 1));

    // One long-division step: remainder and the next 16 bits over 58
    assign w_x    = {r_rem, r_work[63:48]};
    assign w_prod = w_x * blk58_pkg::RECIP_58;
    assign w_q    = w_prod[blk58_pkg::RECIP_SHIFT +: blk58_pkg::CHUNK_BITS];
    // Remainder is below 64, so only the low six bits of 58*q matter
    assign w_q58_lo = 6'({w_q[0], 5'b0}) + 6'({w_q[1:0], 4'b0})
                    + 6'({w_q[2:0], 3'b0}) + 6'({w_q[4:0], 1'b0});
    assign n_rem    = w_x[5:0] - w_q58_lo;

    // Hold accumulator and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (w_flush) begin
                r_acc   <= '0;
                r_count <= '0;
            end else begin
                r_acc   <= n_acc;
                r_count <= r_count + 3'd1;
            end
        end
    end

    // Load the block, then shift quotient chunks in as the division runs
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_flush) begin
            r_work <= n_acc;
            r_rem  <= '0;
            r_len  <= blk58_pkg::run_length({1'b0, r_count} + 4'd1);
            r_last <= i_final_byte;
        end else if (i_cmd.step) begin
            r_work <= {r_work[47:0], w_q};
            r_rem  <= i_cmd.digit_wr ? 6'd0 : n_rem;
        end
    end

    // Store finished digits, least significant first
    always_ff @(posedge i_clk) begin
        if (i_cmd.digit_wr) begin
            r_digits[i_cmd.digit_idx] <= n_rem;
        end
    end

    assign o_status.flush = w_flush;
    assign o_status.len   = r_len;

    // Present the selected digit, most significant first
    assign o_char_code   = blk58_pkg::digit_char(r_digits[i_cmd.rd_idx]);
    assign o_block_end   = (i_cmd.rd_idx == 4'd0);
    assign o_message_end = (i_cmd.rd_idx == 4'd0) & r_last;

endmodule

[design/block_base58_encoder.sv]
// Block base58 encoder: 8-byte blocks to 11 characters, partial final block shorter.
// Throughput: one non-closing byte per cycle. A closing byte holds off intake while its
// block is divided digit by digit, 16 bits per step through the single divide-by-58 step,
// and while its characters are sent, one per cycle unless the output stalls.
// Reset (synchronous, active low) empties the accumulator and returns to byte intake.
module block_base58_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // final_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] char_code, [7] zero
    output logic       o_m_tuser,   // [0] block_end
    output logic       o_m_tlast    // message_end
);

    blk58_pkg::t_cmd    w_cmd;
    blk58_pkg::t_status w_status;
    logic [6:0]         w_char;

    blk58_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    blk58_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_s_tdata),
        .i_final_byte  (i_s_tlast),
        .o_status      (w_status),
        .o_char_code   (w_char),
        .o_block_end   (o_m_tuser),
        .o_message_end (o_m_tlast)
    );

    // Pad the character to a whole byte
    assign o_m_tdata = {1'b0, w_char};

endmodule

[tb/tb_block_base58_encoder.sv]
// Testbench for block_base58_encoder: drives message bytes, predicts the base58 characters
// per block and checks each character, block_end and message_end flag as it arrives.
// Depends only on the design files (block_base58_encoder and blk58_pkg).

// Expected character of one encoded block run
typedef struct packed {
    logic [6:0] code;
    logic       blk_end;
    logic       msg_end;
} t_char;

// Gathers bytes into blocks, converts each closed block to base58 and checks the output
class char_scoreboard;
    logic [63:0]  acc;
    int unsigned  held;
    int unsigned  errors;
    t_char        chars_due[$];
    int unsigned  run_len[9] = '{0, 2, 3, 5, 6, 7, 9, 10, 11};
    string        digits = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    function new();
        acc    = '0;
        held   = 0;
        errors = 0;
    endfunction

    // Append an accepted byte; on a full block or the final byte queue its characters
    function void take_byte(logic [7:0] b, logic fin);
        logic [63:0] v;
        logic [6:0]  codes[11];
        int unsigned n;
        int unsigned len;
        t_char       c;
        acc = {acc[55:0], b};
        n = held + 1;
        if (n == 8 || fin) begin
            len = run_len[n];
            v = acc;
            // Least significant digit first, stored right to left
            for (int i = int'(len) - 1; i >= 0; i--) begin
                codes[i] = 7'(digits[int'(v % 64'd58)]);
                v = v / 64'd58;
            end
            for (int i = 0; i < int'(len); i++) begin
                c.code    = codes[i];
                c.blk_end = (i == int'(len) - 1);
                c.msg_end = (i == int'(len) - 1) && fin;
                chars_due.push_back(c);
            end
            acc  = '0;
            held = 0;
        end else begin
            held = n;
        end
    endfunction

    // Compare one accepted character with the oldest expectation
    function void check_char(logic [6:0] code, logic blk_end, logic msg_end);
        t_char e;
        if (chars_due.size() == 0) begin
            $error("unexpected char: code %0d block_end %0b message_end %0b",
                   code, blk_end, msg_end);
            errors++;
            return;
        end
        e = chars_due.pop_front();
        if (code !== e.code) begin
            $error("char_code: expected %0d, got %0d", e.code, code);
            errors++;
        end
        if (blk_end !== e.blk_end) begin
            $error("block_end: expected %0b, got %0b", e.blk_end, blk_end);
            errors++;
        end
        if (msg_end !== e.msg_end) begin
            $error("message_end: expected %0b, got %0b", e.msg_end, msg_end);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return chars_due.size();
    endfunction
endclass

module tb_block_base58_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STALL_LIMIT = 2000;
    localparam int unsigned TOTAL_ITEMS = 110;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'd0;   // [7:0] data_byte
    logic       i_s_tlast = 1'b0;   // final_byte
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;          // [6:0] char_code, [7] zero
    logic       o_m_tuser;          // [0] block_end
    logic       o_m_tlast;          // message_end

    char_scoreboard sb = new();
    bit          calm = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned ready_hold = 0;
    int unsigned quiet_cycles = 0;

    block_base58_encoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock: 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Note accepted bytes and check accepted characters at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                sb.take_byte(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                sb.check_char(o_m_tdata[6:0], o_m_tuser, o_m_tlast);
                if (o_m_tdata[7] !== 1'b0) begin
                    $error("tdata pad: expected 0, got %0b", o_m_tdata[7]);
                    sb.errors++;
                end
            end
        end
    end

    // Hold off the output in bursts of random length, none once calm
    always @(posedge i_clk) begin
        if (calm) begin
            i_m_tready <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            i_m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_m_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no expected item moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) ||
            (o_m_tvalid && i_m_tready && sb.pending() != 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[block_base58_encoder] ERROR");
                $finish;
            end
        end
    end

    // Offer one byte, with an optional random gap first, and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    // Send a whole message of random bytes, edge values now and then
    task automatic send_message(input int unsigned len);
        logic [7:0] b;
        for (int unsigned k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, k == len - 1);
        end
    endtask

    initial begin
        int unsigned len;
        // Hold reset, then release it
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full block of 0xFF without the final flag: largest value, block_end only
        for (int k = 0; k < 8; k++) send_byte(8'hFF, 1'b0);
        // Full block of zeros closed by the final flag: all padding symbols
        for (int k = 0; k < 8; k++) send_byte(8'h00, k == 7);
        // One-byte messages at both extremes
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        // Short partial blocks
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b1);

        // Random messages up to the item budget; the last part runs without idling
        while (bytes_sent < TOTAL_ITEMS) begin
            if (bytes_sent >= TOTAL_ITEMS * 3 / 4) calm = 1'b1;
            case ($urandom_range(0, 5))
                0:       len = 8;
                1:       len = 16;
                2:       len = $urandom_range(1, 7);
                default: len = $urandom_range(1, 20);
            endcase
            if (len > TOTAL_ITEMS - bytes_sent) len = TOTAL_ITEMS - bytes_sent;
            send_message(len);
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow for any late extra output
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[block_base58_encoder] OK");
        end else begin
            $display("[block_base58_encoder] ERROR");
        end
        $finish;
    end
endmodule
